FILE: rtl/sha1_pkg.sv
// shared types, constants and codes for the sha-1 hash engine
// no dependencies; the datapath, controller and engine import this package
`default_nettype none

package sha1_pkg;

   localparam int unsigned TotalWidth = 61;
   localparam int unsigned FillWidth  = 6;
   localparam int unsigned RoundWidth = 7;

   localparam logic [FillWidth-1:0]  FillLast   = 6'd63;
   localparam logic [FillWidth-1:0]  FillLenPos = 6'd56;
   localparam logic [RoundWidth-1:0] RoundAdd   = 7'd80;
   localparam logic [2:0]            WordLast   = 3'd4;
   localparam logic [7:0]            PadMark    = 8'h80;

   localparam logic [31:0] Iv0 = 32'h67452301;
   localparam logic [31:0] Iv1 = 32'hefcdab89;
   localparam logic [31:0] Iv2 = 32'h98badcfe;
   localparam logic [31:0] Iv3 = 32'h10325476;
   localparam logic [31:0] Iv4 = 32'hc3d2e1f0;

   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   // byte source for the message buffer shift
   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_MARK = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   typedef struct packed {
      logic                  shift_en;
      logic [1:0]            byte_sel;
      logic                  count_byte;
      logic                  set_fail;
      logic                  round_en;
      logic [RoundWidth-1:0] round_num;
      logic                  add_en;
      logic                  restart;
      logic                  out_load;
      logic                  out_err;
      logic [2:0]            out_idx;
      logic                  out_last;
   } sha1_cmd_type;

   typedef struct packed {
      logic [FillWidth-1:0] fill;
      logic                 total_full;
      logic                 failed;
      logic                 out_free;
   } sha1_status_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] v;
      unique case (idx)
         3'd0:    v = Iv0;
         3'd1:    v = Iv1;
         3'd2:    v = Iv2;
         3'd3:    v = Iv3;
         default: v = Iv4;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1_ifs.sv
// valid/ready channel interfaces for the sha-1 hash engine
// request carries one message byte and an end mark, response one digest word
`default_nettype none

interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   logic        length_error;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, output length_error, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, input length_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/sha1_datapath.sv
// sha-1 datapath: message shift buffer, schedule, round registers, hash words,
// byte counters and the response register; uses sha1_pkg
`default_nettype none

module sha1_datapath
   import sha1_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sha1_cmd_type    cmd,
   input  wire logic [7:0]      data_byte,
   input  wire logic            rsp_ready,
   output sha1_status_type      status,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word,
   output logic                 rsp_length_error
);

   logic [31:0]           w_ff [16];
   logic [31:0]           w_in [16];
   logic [31:0]           hash_ff [5];
   logic [31:0]           hash_in [5];
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]           a_in, b_in, c_in, d_in, e_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;
   logic [TotalWidth-1:0] total_ff, total_in;
   logic                  failed_ff, failed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_word_ff;
   logic [2:0]            rsp_idx_ff;
   logic                  rsp_last_ff, rsp_err_ff;

   logic [63:0] bit_len;
   logic [7:0]  len_byte;
   logic [7:0]  shift_byte;
   logic [31:0] f_val, k_val, t_val;

   assign bit_len  = {total_ff, 3'b000};
   // length goes out most significant byte first from fill 56 onwards
   assign len_byte = 8'(bit_len >> {~fill_ff[2:0], 3'b000});

   always_comb begin
      unique case (cmd.byte_sel)
         BSEL_DATA: shift_byte = data_byte;
         BSEL_MARK: shift_byte = PadMark;
         BSEL_ZERO: shift_byte = 8'h00;
         default:   shift_byte = len_byte;
      endcase
   end

   always_comb begin
      logic [31:0] x;
      x = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_in = w_ff;
      if (cmd.shift_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], shift_byte};
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = {x[30:0], x[31]};
      end
   end

   always_comb begin
      if (cmd.round_num < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (cmd.round_num < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (cmd.round_num < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];

   always_comb begin
      hash_in = hash_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.restart) begin
         for (int i = 0; i < 5; i++) begin
            hash_in[i] = iv_word(3'(i));
         end
         a_in = Iv0;
         b_in = Iv1;
         c_in = Iv2;
         d_in = Iv3;
         e_in = Iv4;
      end else if (cmd.add_en) begin
         // round registers follow the hash so the next block starts loaded
         hash_in[0] = hash_ff[0] + a_ff;
         hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff;
         hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff;
         a_in = hash_in[0];
         b_in = hash_in[1];
         c_in = hash_in[2];
         d_in = hash_in[3];
         e_in = hash_in[4];
      end else if (cmd.round_en) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      fill_in   = fill_ff;
      total_in  = total_ff;
      failed_in = failed_ff;
      if (cmd.restart) begin
         fill_in   = '0;
         total_in  = '0;
         failed_in = 1'b0;
      end else begin
         if (cmd.shift_en) begin
            fill_in = fill_ff + 6'd1;
         end
         if (cmd.count_byte) begin
            total_in = total_ff + 61'd1;
         end
         if (cmd.set_fail) begin
            failed_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            hash_ff[i] <= iv_word(3'(i));
         end
         a_ff         <= Iv0;
         b_ff         <= Iv1;
         c_ff         <= Iv2;
         d_ff         <= Iv3;
         e_ff         <= Iv4;
         fill_ff      <= '0;
         total_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         e_ff         <= e_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_word_ff <= cmd.out_err ? 32'd0 : hash_ff[cmd.out_idx];
         rsp_idx_ff  <= cmd.out_err ? 3'd0 : cmd.out_idx;
         rsp_last_ff <= cmd.out_last;
         rsp_err_ff  <= cmd.out_err;
      end
   end

   // fill, total_full, failed, out_free
   assign status = {fill_ff, &total_ff, failed_ff, ~rsp_valid_ff | rsp_ready};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word  = rsp_word_ff;
   assign rsp_word_index   = rsp_idx_ff;
   assign rsp_last_word    = rsp_last_ff;
   assign rsp_length_error = rsp_err_ff;

endmodule

`default_nettype wire

FILE: rtl/sha1_ctrl.sv
// sha-1 controller: sequences absorb, compression rounds, padding and output
// drives sha1_cmd_type towards the datapath; uses sha1_pkg
`default_nettype none

module sha1_ctrl
   import sha1_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_byte_present,
   input  wire logic            req_end_of_message,
   output logic                 req_ready,
   input  wire sha1_status_type status,
   output sha1_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_COMP = 3'd1;
   localparam logic [2:0] S_MARK = 3'd2;
   localparam logic [2:0] S_ZERO = 3'd3;
   localparam logic [2:0] S_PADL = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;
   localparam logic [2:0] S_ERR  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            ret_ff, ret_in;
   logic [RoundWidth-1:0] round_ff, round_in;
   logic [2:0]            word_ff, word_in;

   logic accept, byte_ok, fail_hit, wrap;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign byte_ok   = accept & req_byte_present & ~status.failed & ~status.total_full;
   assign fail_hit  = accept & req_byte_present & ~status.failed & status.total_full;
   assign wrap      = (status.fill == FillLast);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      round_in = round_ff;
      word_in  = word_ff;
      cmd      = '0;
      cmd.byte_sel  = BSEL_DATA;
      cmd.round_num = round_ff;
      cmd.out_idx   = word_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd.shift_en   = byte_ok;
            cmd.count_byte = byte_ok;
            cmd.set_fail   = fail_hit;
            if (byte_ok && wrap) begin
               state_in = S_COMP;
               ret_in   = req_end_of_message ? S_MARK : S_IDLE;
            end else if (accept && req_end_of_message) begin
               state_in = (status.failed || fail_hit) ? S_ERR : S_MARK;
            end
         end
         S_COMP: begin
            if (round_ff == RoundAdd) begin
               cmd.add_en = 1'b1;
               round_in   = '0;
               state_in   = ret_ff;
            end else begin
               cmd.round_en = 1'b1;
               round_in     = round_ff + 7'd1;
            end
         end
         S_MARK: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_MARK;
            if (wrap) begin
               state_in = S_COMP;
               ret_in   = S_PADL;
            end else if (status.fill >= FillLenPos) begin
               // no room left for the length in this block
               state_in = S_ZERO;
            end else begin
               state_in = S_PADL;
            end
         end
         S_ZERO: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_ZERO;
            if (wrap) begin
               state_in = S_COMP;
               ret_in   = S_PADL;
            end
         end
         S_PADL: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = (status.fill < FillLenPos) ? BSEL_ZERO : BSEL_LEN;
            if (wrap) begin
               state_in = S_COMP;
               ret_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (word_ff == WordLast);
               if (word_ff == WordLast) begin
                  cmd.restart = 1'b1;
                  word_in     = '0;
                  state_in    = S_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         S_ERR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = 1'b1;
               cmd.out_last = 1'b1;
               cmd.restart  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sha1_hash_engine.sv
// sha-1 hash engine: one byte beat per cycle while a block fills; every full
// 64-byte block then runs 80 rounds, one per cycle, plus the hash add, during
// which no request is taken. end of message shifts in padding one byte a
// cycle (one or two compressions), then five response beats (one on a length error).
// synchronous reset restores the initial hash and clears counts and the failure
// flag; the same happens after each digest or error response.
`default_nettype none

module sha1_hash_engine
   import sha1_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sha1_req_if.sink    req_chan,
   sha1_rsp_if.source  rsp_chan
);

   sha1_cmd_type    cmd;
   sha1_status_type status;
   logic            req_ready;

   sha1_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_byte_present   (req_chan.byte_present),
      .req_end_of_message (req_chan.end_of_message),
      .req_ready          (req_ready),
      .status             (status),
      .cmd                (cmd)
   );

   assign req_chan.ready = req_ready;

   sha1_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .data_byte        (req_chan.data_byte),
      .rsp_ready        (rsp_chan.ready),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_digest_word  (rsp_chan.digest_word),
      .rsp_word_index   (rsp_chan.word_index),
      .rsp_last_word    (rsp_chan.last_word),
      .rsp_length_error (rsp_chan.length_error)
   );

endmodule

`default_nettype wire

FILE: sim/sha1_hash_engine_tb.sv
// self-checking testbench for sha1_hash_engine: byte beats in, digest word beats out
// depends on rtl/sha1_pkg.sv, rtl/sha1_ifs.sv and rtl/sha1_hash_engine.sv
`default_nettype none

module sha1_hash_engine_tb;
   import sha1_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 300000;
   localparam int unsigned HoldCycles = 500;
   localparam int unsigned DrainCycles = 300;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
      logic        err;
   } digest_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1_req_if req_bus ();
   sha1_rsp_if rsp_bus ();

   sha1_hash_engine uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectations
   req_beat_type    pending_items[$];
   digest_beat_type digest_due[$];
   req_beat_type    next_beat;
   int unsigned     stim_total;
   int unsigned     real_items;
   int unsigned     messages_queued;
   int unsigned     offered;
   logic [1:0]      idle_phase;
   int unsigned     hold_left;
   logic            hold_done;

   // counters
   int unsigned cycle_count;
   int unsigned req_beats;
   int unsigned digest_beats;
   int unsigned messages_done;
   int unsigned compressions;
   int unsigned mismatches;

   // predicted engine state
   logic [31:0]           chain_words[5];
   logic [7:0]            msg_buf[64];
   int unsigned           fill;
   logic [TotalWidth-1:0] msg_bytes;
   logic                  len_failed;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic clear_chain();
      chain_words[0] = Iv0;
      chain_words[1] = Iv1;
      chain_words[2] = Iv2;
      chain_words[3] = Iv3;
      chain_words[4] = Iv4;
      fill = 0;
      msg_bytes = '0;
      len_failed = 1'b0;
   endtask

   task automatic sha1_compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, k, t, wr;
      int unsigned r;
      for (r = 0; r < 16; r++)
         w[r] = {msg_buf[4*r], msg_buf[4*r+1], msg_buf[4*r+2], msg_buf[4*r+3]};
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            wr = rotl(w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[r & 15], 1);
            w[r & 15] = wr;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = rotl(a, 5) + f + e + k + wr;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
      compressions++;
   endtask

   task automatic absorb_byte(input logic [7:0] v);
      if (len_failed)
         return;
      // byte count saturated: drop the byte and latch the failure
      if (msg_bytes == {TotalWidth{1'b1}}) begin
         len_failed = 1'b1;
         return;
      end
      msg_bytes++;
      msg_buf[fill] = v;
      fill++;
      if (fill == 64) begin
         sha1_compress();
         fill = 0;
      end
   endtask

   task automatic predict_digest(input req_beat_type beat);
      logic [63:0]     bit_len;
      digest_beat_type beat_due;
      int unsigned     i;
      if (beat.byte_present)
         absorb_byte(beat.data_byte);
      if (!beat.end_of_message)
         return;
      messages_done++;
      if (len_failed) begin
         beat_due.word = '0;
         beat_due.index = '0;
         beat_due.last = 1'b1;
         beat_due.err = 1'b1;
         digest_due.push_back(beat_due);
         clear_chain();
         return;
      end
      bit_len = {msg_bytes, 3'b000};
      msg_buf[fill] = PadMark;
      fill++;
      // no room left for the length field: pad out and compress an extra block
      if (fill > int'(FillLenPos)) begin
         for (i = fill; i < 64; i++)
            msg_buf[i] = 8'h00;
         sha1_compress();
         fill = 0;
      end
      for (i = fill; i < int'(FillLenPos); i++)
         msg_buf[i] = 8'h00;
      for (i = 0; i < 8; i++)
         msg_buf[63-i] = bit_len[8*i +: 8];
      sha1_compress();
      for (i = 0; i < 5; i++) begin
         beat_due.word = chain_words[i];
         beat_due.index = 3'(i);
         beat_due.last = (3'(i) == WordLast);
         beat_due.err = 1'b0;
         digest_due.push_back(beat_due);
      end
      clear_chain();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s at digest beat %0d: got %h, want %h",
               what, digest_beats, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic queue_beat(input logic [7:0] d, input logic bp, input logic eom);
      req_beat_type b;
      b.data_byte = d;
      b.byte_present = bp;
      b.end_of_message = eom;
      pending_items.push_back(b);
      if (bp || eom)
         real_items++;
   endtask

   task automatic queue_message(input int unsigned len);
      logic        merge_end;
      int unsigned i;
      merge_end = (len != 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 6)
            queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         queue_beat(8'($urandom_range(0, 255)), 1'b1, merge_end && (i == len - 1));
      end
      if (!merge_end)
         queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      messages_queued++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         idle_phase <= 2'd0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_items.size() != 0 &&
             $urandom_range(0, 99) >= (idle_phase == 2'd0 ? 25 :
                                       idle_phase == 2'd1 ? 83 : 0)) begin
            next_beat = pending_items.pop_front();
            req_bus.data_byte <= next_beat.data_byte;
            req_bus.byte_present <= next_beat.byte_present;
            req_bus.end_of_message <= next_beat.end_of_message;
            req_bus.valid <= 1'b1;
            offered++;
            idle_phase <= (offered * 3 < stim_total) ? 2'd0 :
                          (offered * 3 < stim_total * 2) ? 2'd1 : 2'd2;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off once idling stops, so the engine backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && idle_phase == 2'd2) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left != 0)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= $urandom_range(0, 99) >= (idle_phase == 2'd0 ? 83 :
                                                    idle_phase == 2'd1 ? 25 : 0);
   end

   // monitor: predict on each accepted request, check each accepted digest beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_beats++;
            predict_digest({req_bus.data_byte, req_bus.byte_present,
                            req_bus.end_of_message});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digest_due.size() == 0) begin
               report_mismatch("unexpected beat", rsp_bus.digest_word, '0);
            end else begin
               check_field("digest_word", rsp_bus.digest_word, digest_due[0].word);
               check_field("word_index", 32'(rsp_bus.word_index), 32'(digest_due[0].index));
               check_field("last_word", 32'(rsp_bus.last_word), 32'(digest_due[0].last));
               check_field("length_error", 32'(rsp_bus.length_error),
                           32'(digest_due[0].err));
               void'(digest_due.pop_front());
            end
            digest_beats++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d digest beats outstanding",
                  cycle_count, digest_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned pick;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.byte_present = 1'b0;
      req_bus.end_of_message = 1'b0;
      rsp_bus.ready = 1'b0;
      cycle_count = 0;
      offered = 0;
      clear_chain();

      // directed: empty beats, empty message, "abc", extreme bytes, merged end marks
      queue_beat(8'hff, 1'b0, 1'b0);
      queue_beat(8'h00, 1'b0, 1'b1);
      queue_beat(8'h61, 1'b1, 1'b0);
      queue_beat(8'h62, 1'b1, 1'b0);
      queue_beat(8'h63, 1'b1, 1'b1);
      queue_beat(8'h00, 1'b1, 1'b0);
      queue_beat(8'hff, 1'b1, 1'b0);
      queue_beat(8'h5a, 1'b0, 1'b0);
      queue_beat(8'hff, 1'b0, 1'b1);
      queue_beat(8'hff, 1'b1, 1'b1);
      queue_beat(8'h00, 1'b0, 1'b1);
      queue_beat(8'h00, 1'b0, 1'b1);
      queue_beat(8'h55, 1'b1, 1'b0);
      queue_beat(8'haa, 1'b1, 1'b0);
      queue_beat(8'h33, 1'b0, 1'b0);
      queue_beat(8'h00, 1'b1, 1'b1);
      messages_queued = 7;

      // random messages, weighted towards the padding boundaries around 56 and 64
      while (real_items < 380 || messages_queued < 20) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            queue_message($urandom_range(0, 10));
         else if (pick < 82)
            queue_message($urandom_range(53, 66));
         else if (pick < 92)
            queue_message($urandom_range(117, 129));
         else
            queue_message($urandom_range(0, 2));
      end
      stim_total = pending_items.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (req_beats < stim_total)
         @(negedge clock);
      while (digest_due.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("covered %0d request beats, %0d messages, %0d block compressions",
               req_beats, messages_done, compressions);
      $display("checked %0d digest beats, %0d mismatches", digest_beats, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
